### hdl/bar_level_keyframe_animator_unit_defines.svh
// Assertion macros shared by the keyframe animator modules.
`ifndef BAR_LEVEL_KEYFRAME_ANIMATOR_UNIT_DEFINES_SVH
`define BAR_LEVEL_KEYFRAME_ANIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLKA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blka: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BLKA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blka: next-cycle check failed");

`endif

### hdl/blka_pkg.sv
// Types, constants and helper functions of the bar-level keyframe animator.
package blka_pkg;

    localparam int BARS_W = 10;
    localparam int IDX_W  = 4;
    localparam int DUR_W  = 16;
    localparam int LIT_W  = 4;
    localparam int POS_W  = 5;
    localparam int SEQ_W  = 5;
    localparam int STEP_W = 4;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_START = 2'd2,
        REQ_STOP  = 2'd3
    } t_blka_req;

    typedef struct packed {
        t_blka_req          req_type;
        logic [IDX_W-1:0]   frame_index;
        logic [BARS_W-1:0]  frame_bars;
        logic [DUR_W-1:0]   frame_duration_ms;
    } t_blka_in;

    typedef struct packed {
        logic [BARS_W-1:0]  bar_mask;
        logic [LIT_W-1:0]   bars_lit;
        logic               playing;
        logic [POS_W-1:0]   frame_position;
    } t_blka_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_RD_PREV,
        S_RD_CUR,
        S_DIV,
        S_ST_RD,
        S_ST_LD,
        S_DONE
    } t_blka_state;

    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_PREV,
        RSEL_CUR
    } t_blka_rsel;

    typedef struct packed {
        logic       wr_frame;
        logic       stop;
        logic       tick_exec;
        logic       start_ld;
        logic       cap_prev;
        logic       plan;
        logic       div_ld;
        logic       out_ld;
        t_blka_rsel rd_sel;
    } t_blka_cmd;

    typedef struct packed {
        logic need_enter;
        logic div_done;
    } t_blka_sts;

    function automatic logic [STEP_W-1:0] f_popcount(input logic [BARS_W-1:0] v);
        logic [STEP_W-1:0] n;
        n = '0;
        for (int k = 0; k < BARS_W; k++) begin
            n = n + STEP_W'(v[k]);
        end
        return n;
    endfunction

endpackage

### hdl/blka_div.sv
// Restoring divider, one quotient bit per cycle, for the step interval.
module blka_div
    import blka_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DUR_W-1:0]  i_dividend,
    input  logic [STEP_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DUR_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(DUR_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W-1:0] r_dvs;
    logic [DUR_W-1:0]  r_quo;

    logic [STEP_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_quo[DUR_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DUR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the quotient register as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DUR_W-2:0], fits};
            if (fits) begin
                r_rem <= STEP_W'(rem_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= rem_sh[STEP_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hdl/blka_ctrl.sv
// Sequencer of the keyframe animator: request handshake, result register valid.
module blka_ctrl
    import blka_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_blka_req i_req_type,
    input  logic      i_out_stall,
    input  t_blka_sts i_sts,
    output t_blka_cmd o_cmd,
    output logic      o_in_stall,
    output logic      o_out_valid
);

`include "bar_level_keyframe_animator_unit_defines.svh"

    t_blka_state r_state;
    t_blka_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        in_accept;
    logic        out_free;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_req_type)
                        REQ_TICK:  n_state = S_TICK;
                        REQ_START: n_state = S_ST_RD;
                        REQ_WRITE: n_state = S_DONE;
                        REQ_STOP:  n_state = S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_TICK:    n_state = i_sts.need_enter ? S_RD_PREV : S_DONE;
            S_RD_PREV: n_state = S_RD_CUR;
            S_RD_CUR:  n_state = S_DIV;
            S_DIV:     n_state = i_sts.div_done ? S_DONE : S_DIV;
            S_ST_RD:   n_state = S_ST_LD;
            S_ST_LD:   n_state = S_DONE;
            S_DONE:    n_state = out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RSEL_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr_frame = in_accept && (i_req_type == REQ_WRITE);
                o_cmd.stop     = in_accept && (i_req_type == REQ_STOP);
            end
            S_TICK: begin
                o_cmd.tick_exec = 1'b1;
                o_cmd.rd_sel    = RSEL_PREV;
            end
            S_RD_PREV: begin
                o_cmd.cap_prev = 1'b1;
                o_cmd.rd_sel   = RSEL_CUR;
            end
            S_RD_CUR: o_cmd.plan     = 1'b1;
            S_DIV:    o_cmd.div_ld   = i_sts.div_done;
            S_ST_RD:  o_cmd.rd_sel   = RSEL_ZERO;
            S_ST_LD:  o_cmd.start_ld = 1'b1;
            S_DONE:   o_cmd.out_ld   = out_free;
            default:  o_cmd.rd_sel   = RSEL_ZERO;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `BLKA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_in_stall)
    `BLKA_ASSERT_IMP(a_no_result_overwrite, i_clk, i_rst_n, o_cmd.out_ld, !r_out_valid || !i_out_stall)
    `BLKA_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, i_sts.div_done, r_state == S_DIV)

endmodule

### hdl/blka_dpath.sv
// Datapath of the keyframe animator: keyframe memory, playback state, result register.
module blka_dpath
    import blka_pkg::*;
#(
    parameter int NUM_BARS   = 10,
    parameter int MAX_FRAMES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_blka_in         i_in,
    input  logic             i_cfg_we,
    input  logic [SEQ_W-1:0] i_cfg_wdata,
    input  t_blka_cmd        i_cmd,
    output t_blka_sts        o_sts,
    output t_blka_out        o_out
);

`include "bar_level_keyframe_animator_unit_defines.svh"

    localparam int LW       = $clog2(NUM_BARS + 1);
    localparam int IW       = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int FW       = $clog2(MAX_FRAMES + 1);
    localparam int AW       = $clog2(MAX_FRAMES);
    localparam int MEM_W    = BARS_W + DUR_W;
    localparam int PAT_BITS = (NUM_BARS < BARS_W) ? NUM_BARS : BARS_W;
    localparam logic [BARS_W-1:0] PAT_MASK = BARS_W'((64'(1) << PAT_BITS) - 64'(1));

    // Keyframe memory: pattern in the upper bits, duration below.
    logic [MEM_W-1:0]    r_mem [MAX_FRAMES];
    logic [MEM_W-1:0]    r_rd;

    logic [SEQ_W-1:0]    r_seq;
    logic [NUM_BARS-1:0] r_disp,     n_disp;
    logic [LW-1:0]       r_lit,      n_lit;
    logic [FW-1:0]       r_cur,      n_cur;
    logic                r_entered,  n_entered;
    logic [STEP_W-1:0]   r_steps,    n_steps;
    logic                r_ramp,     n_ramp;
    logic [DUR_W-1:0]    r_interval, n_interval;
    logic [DUR_W-1:0]    r_elapsed,  n_elapsed;
    logic                r_running,  n_running;
    logic [STEP_W-1:0]   r_prev_n;
    t_blka_out           r_out;

    logic [AW+IDX_W-1:0]        wr_ext;
    logic [AW-1:0]              wr_addr;
    logic                       wr_ok;
    logic [AW-1:0]              rd_addr;
    logic [FW-1:0]              cur_dec;
    logic [FW-1:0]              cur_inc;
    logic [FW-1:0]              eff_len;
    logic [BARS_W-1:0]          rd_pat;
    logic [DUR_W-1:0]           rd_dur;
    logic [STEP_W-1:0]          rd_pop;
    logic [NUM_BARS+BARS_W-1:0] pat_ext;
    logic [LW+STEP_W-1:0]       pop_ext;
    logic [DUR_W-1:0]           elapsed_inc;
    logic [LW-1:0]              lit_dec;
    logic [STEP_W-1:0]          steps_dec;
    logic                       plan_up;
    logic [STEP_W-1:0]          plan_steps;
    logic [STEP_W-1:0]          plan_div;
    logic                       div_done;
    logic [DUR_W-1:0]           div_quo;
    logic [NUM_BARS+BARS_W-1:0] disp_ext;
    logic [LW+LIT_W-1:0]        lit_ext;
    logic [FW+POS_W-1:0]        cur_ext;

    assign wr_ext  = {AW'(0), i_in.frame_index};
    assign wr_addr = wr_ext[AW-1:0];
    assign wr_ok   = (32'(i_in.frame_index) < MAX_FRAMES);
    assign cur_dec = (r_cur == '0) ? '0 : r_cur - FW'(1);
    assign cur_inc = r_cur + FW'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RSEL_PREV: rd_addr = cur_dec[AW-1:0];
            RSEL_CUR:  rd_addr = r_cur[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_frame && wr_ok) begin
            r_mem[wr_addr] <= {i_in.frame_bars & PAT_MASK, i_in.frame_duration_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    assign rd_pat  = r_rd[MEM_W-1:DUR_W];
    assign rd_dur  = r_rd[DUR_W-1:0];
    assign rd_pop  = f_popcount(rd_pat);
    assign pat_ext = {NUM_BARS'(0), rd_pat};
    assign pop_ext = {LW'(0), rd_pop};

    // A length of zero plays one keyframe; a length past the table plays the table.
    always_comb begin
        if (r_seq == '0) begin
            eff_len = FW'(1);
        end else if (32'(r_seq) > MAX_FRAMES) begin
            eff_len = FW'(MAX_FRAMES);
        end else begin
            eff_len = FW'(r_seq);
        end
    end

    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + DUR_W'(1);
    assign lit_dec     = r_lit - LW'(1);
    assign steps_dec   = (r_steps != '0) ? r_steps - STEP_W'(1) : '0;

    assign plan_up    = (rd_pop >= r_prev_n);
    assign plan_steps = plan_up ? rd_pop - r_prev_n : r_prev_n - rd_pop;
    assign plan_div   = (plan_steps > STEP_W'(1)) ? plan_steps : STEP_W'(1);

    blka_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.plan),
        .i_dividend (rd_dur),
        .i_divisor  (plan_div),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_disp     = r_disp;
        n_lit      = r_lit;
        n_cur      = r_cur;
        n_entered  = r_entered;
        n_steps    = r_steps;
        n_ramp     = r_ramp;
        n_interval = r_interval;
        n_elapsed  = r_elapsed;
        n_running  = r_running;

        if (i_cmd.stop) begin
            n_running = 1'b0;
        end

        if (i_cmd.start_ld) begin
            n_cur      = '0;
            n_entered  = 1'b1;
            n_steps    = '0;
            n_ramp     = 1'b0;
            n_interval = '0;
            n_elapsed  = '0;
            n_disp     = pat_ext[NUM_BARS-1:0];
            n_lit      = pop_ext[LW-1:0];
            n_running  = 1'b1;
        end

        if (i_cmd.tick_exec && r_running) begin
            if (r_cur >= eff_len) begin
                // The length was lowered under a running animation.
                n_running = 1'b0;
            end else begin
                n_elapsed = elapsed_inc;
                if (r_entered && (elapsed_inc >= r_interval)) begin
                    if (r_steps != '0) begin
                        if (r_ramp) begin
                            if (r_lit < LW'(NUM_BARS)) begin
                                n_disp[r_lit[IW-1:0]] = 1'b1;
                                n_lit = r_lit + LW'(1);
                            end
                        end else if (r_lit != '0) begin
                            n_disp[lit_dec[IW-1:0]] = 1'b0;
                            n_lit = lit_dec;
                        end
                        n_steps = steps_dec;
                    end
                    n_elapsed = '0;
                    if (steps_dec == '0) begin
                        n_cur     = cur_inc;
                        n_entered = 1'b0;
                        if (cur_inc >= eff_len) begin
                            n_running = 1'b0;
                        end
                    end
                end
            end
        end

        if (i_cmd.plan) begin
            n_ramp  = plan_up;
            n_steps = plan_steps;
        end

        if (i_cmd.div_ld) begin
            n_interval = div_quo;
            n_entered  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SEQ_W'(1);
            r_disp     <= '0;
            r_lit      <= '0;
            r_cur      <= '0;
            r_entered  <= 1'b1;
            r_steps    <= '0;
            r_ramp     <= 1'b0;
            r_interval <= '0;
            r_elapsed  <= '0;
            r_running  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seq <= i_cfg_wdata;
            end
            r_disp     <= n_disp;
            r_lit      <= n_lit;
            r_cur      <= n_cur;
            r_entered  <= n_entered;
            r_steps    <= n_steps;
            r_ramp     <= n_ramp;
            r_interval <= n_interval;
            r_elapsed  <= n_elapsed;
            r_running  <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_prev) begin
            r_prev_n <= rd_pop;
        end
    end

    assign disp_ext = {BARS_W'(0), r_disp};
    assign lit_ext  = {LIT_W'(0), r_lit};
    assign cur_ext  = {POS_W'(0), r_cur};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out.bar_mask       <= disp_ext[BARS_W-1:0];
            r_out.bars_lit       <= lit_ext[LIT_W-1:0];
            r_out.playing        <= r_running;
            r_out.frame_position <= cur_ext[POS_W-1:0];
        end
    end

    assign o_sts.need_enter = r_running && (r_cur < eff_len) && !r_entered;
    assign o_sts.div_done   = div_done;
    assign o_out            = r_out;

    `BLKA_ASSERT_IMP(a_lit_bound, i_clk, i_rst_n, 1'b1, r_lit <= LW'(NUM_BARS))
    `BLKA_ASSERT_NXT(a_start_loads, i_clk, i_rst_n, i_cmd.start_ld, r_running && (r_cur == '0) && r_entered)
    `BLKA_ASSERT_NXT(a_idle_tick, i_clk, i_rst_n, i_cmd.tick_exec && !r_running, $stable(r_cur) && $stable(r_disp) && !r_running)

endmodule

### hdl/bar_level_keyframe_animator_unit.sv
// Top level of the bar-level keyframe animator.
//
// Requests enter on i_in (i_in_valid, o_in_stall): a one-millisecond tick, a keyframe
// write, start or stop. Every request yields exactly one result on o_out
// (o_out_valid, i_out_stall): the display pattern, lit-bar count, playing flag and
// current keyframe position after that request.
// The keyframe count is written through i_cfg_we / i_cfg_wdata; the user is to
// write it only while the block is idle, which the block itself does not enforce.
// Requests are handled one at a time. A write or stop goes straight to its result;
// a start first reads keyframe zero, and a plain tick updates the playback state. The tick
// that enters a new keyframe reads the previous and current entries from the keyframe
// memory and runs a bit-serial divider that yields sixteen quotient bits for the step interval.
// A finished result waits in an output register, so the next request is taken while
// the receiver stalls; a second result waits in the block until the register frees.
// Synchronous reset stops playback, clears the display and sets the length to one.
// The keyframe memory is not cleared: entries are to be written before playback.
module bar_level_keyframe_animator_unit
    import blka_pkg::*;
#(
    parameter int NUM_BARS   = 10,
    parameter int MAX_FRAMES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_blka_in         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_blka_out        o_out,
    input  logic             i_cfg_we,
    input  logic [SEQ_W-1:0] i_cfg_wdata
);

    t_blka_cmd cmd;
    t_blka_sts sts;

    blka_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in.req_type),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    blka_dpath #(
        .NUM_BARS   (NUM_BARS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule
